@@ design/msd_pkg.sv @@
package msd_pkg;

  // fixed field widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 3;
  localparam int THR_W   = 8;
  localparam int RAD_W   = 4;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_RADIUS       = 3'd2;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FILL         = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [RAD_W-1:0] RADIUS_RST       = 4'd4;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd128;
  localparam logic [PIX_W-1:0] FILL_RST         = 8'd255;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = 2;
  localparam int OQ_CW    = 3;

  // per-transfer flags handed from the position control to the window logic
  typedef struct packed {
    logic adv;       // transfer advances the stream position
    logic emit;      // transfer releases one output pixel
    logic last;      // released pixel is the last of the frame
    logic marked;    // incoming pixel is above threshold
    logic row0;      // input row 0, column history is stale
    logic col0;      // input column 0, row history restarts
    logic row_end;   // last column of an input row
    logic vrow;      // input row is at least radius rows down
    logic fwd;       // column entry written by the previous transfer
    logic own_fwd;   // zero lag, own pixel is the incoming one
  } msd_step_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pixel;
  } msd_res_t;

endpackage

@@ design/mask_square_dilation.sv @@
// out_tvalid rises once the transfer that completes a pixel's window, i.e. the transfer
//   radius*width+radius stream positions after that pixel, has passed the s1 registers and the output queue
// throughput: one pixel per cycle while in_tready is high, bounded by the single write port of the pixel delay
//   memory and the read-modify-write of the column mark memory (forwarded when back to back)
// reset: rst_n is synchronous, active low; it clears the stream counters, the output queue
//   and the registers to their defaults; the memories keep their contents, no clearing pass
module mask_square_dilation import msd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // [7:0] pixel_in
  input  logic              in_tuser,   // [0] flush
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,  // [7:0] pixel_out
  output logic              out_tlast,  // frame_end
  // register writes
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int XW        = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int RW        = $clog2(MAX_RADIUS + 1);
  localparam int DW        = $clog2(2 * MAX_RADIUS + 2);
  localparam int LAG_DEPTH = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
  localparam int LW        = $clog2(LAG_DEPTH + 1);
  localparam int AW        = LAG_DEPTH > 1 ? $clog2(LAG_DEPTH) : 1;
  localparam int PW        = RW + WW;

  // configuration registers
  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic [RAD_W-1:0] radius_r;
  logic [THR_W-1:0] thr_r;
  logic [PIX_W-1:0] fill_r;

  // clamped geometry and the stream lag in positions
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [RW-1:0] r;
  logic [PW-1:0] rw_prod;
  logic [LW-1:0] lag;

  logic             acc;
  logic             pix_we;
  logic [AW-1:0]    pix_waddr, pix_raddr;
  logic [PIX_W-1:0] pix_rdata;
  logic [XW-1:0]    col_raddr, col_waddr;
  logic             col_we;
  logic [DW-1:0]    col_wdata, col_rdata;
  logic             s1_v;
  msd_step_t        s1_step;
  logic [XW-1:0]    s1_xi, s1_xo;
  logic [RW-1:0]    s1_k;
  logic [PIX_W-1:0] s1_pix;
  logic             res_v;
  msd_res_t         res, oq_head;
  logic [OQ_CW-1:0] oq_count;
  logic             s1_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      radius_r       <= RADIUS_RST;
      thr_r          <= THRESHOLD_RST;
      fill_r         <= FILL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        REG_RADIUS:       radius_r       <= cfg_wdata[RAD_W-1:0];
        REG_THRESHOLD:    thr_r          <= cfg_wdata[THR_W-1:0];
        REG_FILL:         fill_r         <= cfg_wdata[PIX_W-1:0];
        default:          ;  // unused indexes are dropped
      endcase
    end
  end

  // zero width or height counts as one, oversize counts as the maximum
  always_comb begin
    if (frame_width_r == '0) begin
      w = WW'(1);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h = HW'(1);
    end else if (int'(frame_height_r) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height_r);
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      r = RW'(MAX_RADIUS);
    end else begin
      r = RW'(radius_r);
    end
    rw_prod = PW'(r) * PW'(w);
    lag     = LW'(rw_prod + PW'(r));
  end

  // the queue must hold the result still in flight plus the one accepted now
  assign s1_emit   = s1_v && s1_step.emit;
  assign in_tready = ((OQ_CW+1)'(oq_count) + (OQ_CW+1)'(s1_emit)) < (OQ_CW+1)'(OQ_DEPTH);
  assign acc       = in_tvalid && in_tready;

  // stream positions, lag countdown and ring buffer addressing
  msd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .flush     (in_tuser),
    .pixel     (in_tdata),
    .w         (w),
    .h         (h),
    .r         (r),
    .lag       (lag),
    .thr       (thr_r),
    .pix_we    (pix_we),
    .pix_waddr (pix_waddr),
    .pix_raddr (pix_raddr),
    .col_raddr (col_raddr),
    .s1_v      (s1_v),
    .s1_step   (s1_step),
    .s1_xi     (s1_xi),
    .s1_xo     (s1_xo),
    .s1_k      (s1_k),
    .s1_pix    (s1_pix)
  );

  // pixel delay line: ring buffer as deep as the largest lag
  msd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LAG_DEPTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (in_tdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // per column: rows since the last marked pixel
  msd_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // vertical then horizontal window test and output pixel select
  msd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_core (
    .clk       (clk),
    .s1_v      (s1_v),
    .step      (s1_step),
    .xi        (s1_xi),
    .xo        (s1_xo),
    .k         (s1_k),
    .pix       (s1_pix),
    .r         (r),
    .thr       (thr_r),
    .fill      (fill_r),
    .col_rdata (col_rdata),
    .pix_rdata (pix_rdata),
    .col_we    (col_we),
    .col_waddr (col_waddr),
    .col_wdata (col_wdata),
    .res_v     (res_v),
    .res       (res)
  );

  // output queue decouples a stalled consumer from the pipeline
  msd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .pop       (out_tready),
    .valid     (out_tvalid),
    .head      (oq_head),
    .count     (oq_count)
  );

  assign out_tdata = oq_head.pixel;
  assign out_tlast = oq_head.last;

  // queue never receives a result with no room for it
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |-> (oq_count < OQ_CW'(OQ_DEPTH)) || (out_tvalid && out_tready))
    else $error("output queue overflow");

  // a released pixel always comes from a transfer that advanced the stream
  a_emit_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v && s1_step.emit |-> s1_step.adv)
    else $error("result from a transfer that did not advance");

  // column forwarding only follows an advancing transfer in the previous cycle
  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v && s1_step.fwd |-> $past(s1_v && s1_step.adv, 1) || !$past(rst_n, 1))
    else $error("column forward without a preceding write");

endmodule

@@ design/msd_ram.sv @@
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ design/msd_ctrl.sv @@
module msd_ctrl import msd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8,
  localparam int WW        = $clog2(MAX_WIDTH + 1),
  localparam int XW        = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1,
  localparam int HW        = $clog2(MAX_HEIGHT + 1),
  localparam int YW        = $clog2(MAX_HEIGHT + MAX_RADIUS + 2),
  localparam int RW        = $clog2(MAX_RADIUS + 1),
  localparam int LAG_DEPTH = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS,
  localparam int LW        = $clog2(LAG_DEPTH + 1),
  localparam int AW        = LAG_DEPTH > 1 ? $clog2(LAG_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             flush,
  input  logic [PIX_W-1:0] pixel,
  input  logic [WW-1:0]    w,
  input  logic [HW-1:0]    h,
  input  logic [RW-1:0]    r,
  input  logic [LW-1:0]    lag,
  input  logic [THR_W-1:0] thr,
  output logic             pix_we,
  output logic [AW-1:0]    pix_waddr,
  output logic [AW-1:0]    pix_raddr,
  output logic [XW-1:0]    col_raddr,
  output logic             s1_v,
  output msd_step_t        s1_step,
  output logic [XW-1:0]    s1_xi,
  output logic [XW-1:0]    s1_xo,
  output logic [RW-1:0]    s1_k,
  output logic [PIX_W-1:0] s1_pix
);

  logic [XW-1:0]    xi_r, xi_nxt, xo_r, xo_nxt, prev_x_r;
  logic [YW-1:0]    yi_r, yi_nxt, yo_r, yo_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt, pre_cnt;
  logic             fresh_r, fresh_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic             prev_adv_r;
  logic             drain, adv, emit, last;
  logic             col_last, out_col_last, out_row_last;
  logic [LW:0]      wp_x, lag_x;
  msd_step_t        step;
  logic             s1_v_r;
  msd_step_t        s1_step_r;
  logic [XW-1:0]    s1_xi_r, s1_xo_r;
  logic [RW-1:0]    s1_k_r;
  logic [PIX_W-1:0] s1_pix_r;

  always_comb begin
    drain        = yi_r >= YW'(h);
    adv          = drain || !flush;
    pre_cnt      = fresh_r ? lag : cnt_r;
    emit         = adv && (pre_cnt == '0);
    col_last     = WW'(xi_r) == w - WW'(1);
    out_col_last = WW'(xo_r) == w - WW'(1);
    out_row_last = yo_r == YW'(h) - YW'(1);
    last         = emit && out_col_last && out_row_last;

    xi_nxt    = xi_r;
    yi_nxt    = yi_r;
    xo_nxt    = xo_r;
    yo_nxt    = yo_r;
    cnt_nxt   = cnt_r;
    fresh_nxt = fresh_r;
    wp_nxt    = wp_r;
    if (acc && adv) begin
      fresh_nxt = 1'b0;
      cnt_nxt   = emit ? '0 : pre_cnt - LW'(1);
      wp_nxt    = (wp_r == AW'(LAG_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (col_last) begin
        xi_nxt = '0;
        yi_nxt = yi_r + YW'(1);
      end else begin
        xi_nxt = xi_r + XW'(1);
      end
      if (emit) begin
        if (out_col_last) begin
          xo_nxt = '0;
          yo_nxt = yo_r + YW'(1);
        end else begin
          xo_nxt = xo_r + XW'(1);
        end
      end
      if (last) begin
        xi_nxt    = '0;
        yi_nxt    = '0;
        xo_nxt    = '0;
        yo_nxt    = '0;
        cnt_nxt   = '0;
        fresh_nxt = 1'b1;
      end
    end

    step.adv     = adv;
    step.emit    = emit;
    step.last    = last;
    step.marked  = !drain && (pixel > thr);
    step.row0    = yi_r == '0;
    step.col0    = xi_r == '0;
    step.row_end = col_last;
    step.vrow    = yi_r >= YW'(r);
    step.fwd     = prev_adv_r && (prev_x_r == xi_r);
    step.own_fwd = lag == '0;

    // ring buffer read slot lies lag positions behind the write slot
    wp_x  = (LW+1)'(wp_r);
    lag_x = (LW+1)'(lag);
    if (wp_x >= lag_x) begin
      pix_raddr = AW'(wp_x - lag_x);
    end else begin
      pix_raddr = AW'(wp_x + (LW+1)'(LAG_DEPTH) - lag_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xi_r       <= '0;
      yi_r       <= '0;
      xo_r       <= '0;
      yo_r       <= '0;
      cnt_r      <= '0;
      fresh_r    <= 1'b1;
      wp_r       <= '0;
      prev_adv_r <= 1'b0;
      s1_v_r     <= 1'b0;
    end else begin
      xi_r       <= xi_nxt;
      yi_r       <= yi_nxt;
      xo_r       <= xo_nxt;
      yo_r       <= yo_nxt;
      cnt_r      <= cnt_nxt;
      fresh_r    <= fresh_nxt;
      wp_r       <= wp_nxt;
      prev_adv_r <= acc && adv;
      s1_v_r     <= acc;
    end
  end

  always_ff @(posedge clk) begin
    prev_x_r  <= xi_r;
    s1_step_r <= step;
    s1_xi_r   <= xi_r;
    s1_xo_r   <= xo_r;
    s1_k_r    <= RW'(yi_r - yo_r - YW'(r));
    s1_pix_r  <= pixel;
  end

  assign pix_we    = acc && adv;
  assign pix_waddr = wp_r;
  assign col_raddr = xi_r;
  assign s1_v      = s1_v_r;
  assign s1_step   = s1_step_r;
  assign s1_xi     = s1_xi_r;
  assign s1_xo     = s1_xo_r;
  assign s1_k      = s1_k_r;
  assign s1_pix    = s1_pix_r;

endmodule

@@ design/msd_core.sv @@
module msd_core import msd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8,
  localparam int XW        = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1,
  localparam int RW        = $clog2(MAX_RADIUS + 1),
  localparam int DW        = $clog2(2 * MAX_RADIUS + 2),
  localparam int HIW       = MAX_RADIUS > 1 ? $clog2(MAX_RADIUS) : 1
) (
  input  logic             clk,
  input  logic             s1_v,
  input  msd_step_t        step,
  input  logic [XW-1:0]    xi,
  input  logic [XW-1:0]    xo,
  input  logic [RW-1:0]    k,
  input  logic [PIX_W-1:0] pix,
  input  logic [RW-1:0]    r,
  input  logic [THR_W-1:0] thr,
  input  logic [PIX_W-1:0] fill,
  input  logic [DW-1:0]    col_rdata,
  input  logic [PIX_W-1:0] pix_rdata,
  output logic             col_we,
  output logic [XW-1:0]    col_waddr,
  output logic [DW-1:0]    col_wdata,
  output logic             res_v,
  output msd_res_t         res
);

  localparam logic [DW-1:0] SAT = DW'(2 * MAX_RADIUS + 1);
  localparam int CMP_W = XW + RW + 1;

  logic [DW-1:0]    wr_val_r;
  logic             lm_v_r;
  logic [XW-1:0]    lm_col_r;
  logic             hist_v_r   [MAX_RADIUS];
  logic [XW-1:0]    hist_col_r [MAX_RADIUS];
  logic [DW-1:0]    old, cnew;
  logic             vmark, lm_new_v, sel_v, mark, upd;
  logic [XW-1:0]    lm_new_col, sel_col;
  logic [PIX_W-1:0] own;

  always_comb begin
    // rows since the last mark in this column, saturating
    old  = step.row0 ? SAT : (step.fwd ? wr_val_r : col_rdata);
    cnew = step.marked ? '0 : ((old >= SAT) ? SAT : old + DW'(1));
    vmark = step.vrow && ((RW+DW)'(cnew) <= (RW+DW)'({r, 1'b0}));

    // last column with a vertical mark in the current row
    lm_new_v   = vmark || (!step.col0 && lm_v_r);
    lm_new_col = vmark ? xi : lm_col_r;

    if (k == '0) begin
      sel_v   = lm_new_v;
      sel_col = lm_new_col;
    end else begin
      sel_v   = hist_v_r[HIW'(k - RW'(1))];
      sel_col = hist_col_r[HIW'(k - RW'(1))];
    end
    mark = sel_v && (CMP_W'(sel_col) + CMP_W'(r) >= CMP_W'(xo));

    own       = step.own_fwd ? pix : pix_rdata;
    res.pixel = ((own <= thr) && mark) ? fill : own;
    res.last  = step.last;
  end

  assign upd       = s1_v && step.adv;
  assign res_v     = s1_v && step.emit;
  assign col_we    = upd;
  assign col_waddr = xi;
  assign col_wdata = cnew;

  always_ff @(posedge clk) begin
    if (upd) begin
      wr_val_r <= cnew;
      lm_v_r   <= lm_new_v;
      lm_col_r <= lm_new_col;
      if (step.row_end) begin
        for (int i = MAX_RADIUS - 1; i > 0; i--) begin
          hist_v_r[i]   <= hist_v_r[i-1];
          hist_col_r[i] <= hist_col_r[i-1];
        end
        hist_v_r[0]   <= lm_new_v;
        hist_col_r[0] <= lm_new_col;
      end
    end
  end

endmodule

@@ design/msd_outq.sv @@
module msd_outq import msd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  msd_res_t         push_data,
  input  logic             pop,
  output logic             valid,
  output msd_res_t         head,
  output logic [OQ_CW-1:0] count
);

  msd_res_t         mem_r [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_r, rd_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign valid  = cnt_r != '0;
  assign do_pop = pop && valid;
  assign head   = mem_r[rd_r];
  assign count  = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + OQ_CW'(1);
      2'b01:   cnt_nxt = cnt_r - OQ_CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + OQ_PW'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + OQ_PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule
